[hdl/spra_pkg.sv]
// ----------------------------------------------------------------------------
// spra_pkg: shared definitions for the stereo point reprojection block
// Widths of the fixed-point datapath, status and register codes, and the
// arctangent table used by the CORDIC stages.
// ----------------------------------------------------------------------------
package spra_pkg;

  // Pixel coordinate width.
  localparam int COORD_BITS = 10;
  localparam int DISP_W     = 13;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int DEPTH_W    = 16;
  localparam int PNT_W      = 32;
  localparam int ANGO_W     = 16;

  // Reprojection datapath widths.
  localparam int PROD_W = 45;          // disparity times inv_baseline
  localparam int DEN_W  = 46;          // signed denominator, 28 fraction bits
  localparam int DMAG_W = 45;          // magnitude of the denominator
  localparam int NUM_W  = 34;          // signed numerator, 16 fraction bits
  localparam int MAGN_W = NUM_W - 1;   // magnitude of the numerator
  localparam int N_W    = MAGN_W + 22; // 2*|num|*2^20 + |den|
  localparam int D2_W   = DMAG_W + 1;  // 2*|den|
  localparam int QUO_W  = 32;          // quotient bits, one per stage

  // Azimuth datapath widths.
  localparam int DZ_W         = 34;
  localparam int NORM_W       = 41;
  localparam int NORM_STAGES  = 3;
  localparam int COR_W        = 44;
  localparam int ANG_W        = 28;
  localparam int CORDIC_ITERS = 20;
  localparam int CORDIC_LAT   = NORM_STAGES + CORDIC_ITERS;

  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 16'd370;
  localparam logic signed [ANG_W-1:0] ANG_MAX = 28'sd94371840; // 90 degrees
  localparam logic signed [ANG_W-1:0] ANG_HALF_LSB = 28'sd2048;
  localparam int ANG_DROP = 12;

  // atan(2^-i) in degrees with 20 fraction bits.
  localparam logic signed [ANG_W-1:0] ATAN_TAB [CORDIC_ITERS] = '{
    28'sd47185920, 28'sd27855475, 28'sd14718068, 28'sd7471121, 28'sd3750058,
    28'sd1876857,  28'sd938658,   28'sd469357,   28'sd234682,  28'sd117342,
    28'sd58671,    28'sd29335,    28'sd14668,    28'sd7334,    28'sd3667,
    28'sd1833,     28'sd917,      28'sd458,      28'sd229,     28'sd115
  };

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_DEN_ZERO = 2'd1,
    STATUS_DEPTH_EQ = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_X     = 3'd0,
    CFG_OFFSET_Y     = 3'd1,
    CFG_FOCAL_LENGTH = 3'd2,
    CFG_INV_BASELINE = 3'd3,
    CFG_CENTER_SHIFT = 3'd4,
    CFG_ARRAY_DEPTH  = 3'd5
  } cfg_idx_e;

endpackage

[hdl/spra_divider.sv]
// ----------------------------------------------------------------------------
// spra_divider: pipelined restoring divider
// One quotient bit per stage over 32 stages, with an overflow flag for
// quotients that do not fit in 32 bits.
// ----------------------------------------------------------------------------
module spra_divider (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [spra_pkg::N_W-1:0]    num_i,
  input  logic [spra_pkg::D2_W-1:0]   den_i,
  output logic [spra_pkg::QUO_W-1:0]  quo_o,
  output logic                        ovf_o
);
  import spra_pkg::*;

  typedef struct packed {
    logic [D2_W-1:0]  rem;
    logic [QUO_W-1:0] low;
    logic [QUO_W-1:0] quo;
    logic [D2_W-1:0]  den;
    logic             ovf;
  } div_stage_t;

  function automatic div_stage_t div_step(input div_stage_t s);
    div_stage_t      r;
    logic [D2_W:0]   trial;
    r     = s;
    trial = {s.rem, s.low[QUO_W-1]};
    r.low = {s.low[QUO_W-2:0], 1'b0};
    if (trial >= {1'b0, s.den}) begin
      r.rem = D2_W'(trial - {1'b0, s.den});
      r.quo = {s.quo[QUO_W-2:0], 1'b1};
    end else begin
      r.rem = trial[D2_W-1:0];
      r.quo = {s.quo[QUO_W-2:0], 1'b0};
    end
    return r;
  endfunction

  div_stage_t init_s;
  div_stage_t stg_q [QUO_W];

  // The upper numerator bits must stay below the divisor, else the quotient
  // needs more than 32 bits.
  always_comb begin
    init_s.rem = D2_W'(num_i[N_W-1:QUO_W]);
    init_s.low = num_i[QUO_W-1:0];
    init_s.quo = '0;
    init_s.den = den_i;
    init_s.ovf = D2_W'(num_i[N_W-1:QUO_W]) >= den_i;
  end

  for (genvar j = 0; j < QUO_W; j++) begin : g_stage
    div_stage_t nxt;
    if (j == 0) begin : g_first
      assign nxt = div_step(init_s);
    end else begin : g_rest
      assign nxt = div_step(stg_q[j-1]);
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stg_q[j] <= nxt;
      end
    end
  end

  assign quo_o = stg_q[QUO_W-1].quo;
  assign ovf_o = stg_q[QUO_W-1].ovf;

endmodule

[hdl/spra_cordic.sv]
// ----------------------------------------------------------------------------
// spra_cordic: pipelined arctangent in degrees
// Normalizes both magnitudes together, then runs twenty CORDIC vectoring
// iterations, one per stage.
// ----------------------------------------------------------------------------
module spra_cordic (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [spra_pkg::NORM_W-1:0]        a_i,
  input  logic [spra_pkg::NORM_W-1:0]        b_i,
  output logic signed [spra_pkg::ANG_W-1:0]  z_o
);
  import spra_pkg::*;

  typedef struct packed {
    logic [NORM_W-1:0] a;
    logic [NORM_W-1:0] b;
  } norm_t;

  typedef struct packed {
    logic signed [COR_W-1:0] a;
    logic signed [COR_W-1:0] b;
    logic signed [ANG_W-1:0] z;
  } cor_t;

  localparam int NORM_SHIFT [NORM_STAGES] = '{32, 8, 2};

  // Shift both left by k when their top k bits are all clear.
  function automatic norm_t norm_step(input norm_t s, input int k);
    norm_t             r;
    logic [NORM_W-1:0] m;
    r = s;
    m = s.a | s.b;
    if ((m >> (NORM_W - k)) == '0) begin
      r.a = s.a << k;
      r.b = s.b << k;
    end
    return r;
  endfunction

  function automatic cor_t cor_step(input cor_t s, input int i);
    cor_t                    r;
    logic                    bneg;
    logic signed [COR_W-1:0] bm;
    logic signed [COR_W-1:0] as;
    bneg = s.b[COR_W-1];
    bm   = bneg ? -s.b : s.b;
    as   = s.a >>> i;
    r.a  = s.a + (bm >>> i);
    if (bneg) begin
      r.b = s.b + as;
      r.z = s.z - ATAN_TAB[i];
    end else begin
      r.b = s.b - as;
      r.z = s.z + ATAN_TAB[i];
    end
    return r;
  endfunction

  norm_t norm_in;
  norm_t norm_q [NORM_STAGES];
  cor_t  cor_in;
  cor_t  cor_q [CORDIC_ITERS];

  assign norm_in.a = a_i;
  assign norm_in.b = b_i;

  for (genvar n = 0; n < NORM_STAGES; n++) begin : g_norm
    norm_t src;
    if (n == 0) begin : g_first
      assign src = norm_in;
    end else begin : g_rest
      assign src = norm_q[n-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        norm_q[n] <= norm_step(norm_step(src, NORM_SHIFT[n]), NORM_SHIFT[n] / 2);
      end
    end
  end

  assign cor_in.a = COR_W'(norm_q[NORM_STAGES-1].a);
  assign cor_in.b = COR_W'(norm_q[NORM_STAGES-1].b);
  assign cor_in.z = '0;

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
    cor_t src;
    if (i == 0) begin : g_first
      assign src = cor_in;
    end else begin : g_rest
      assign src = cor_q[i-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cor_q[i] <= cor_step(src, i);
      end
    end
  end

  assign z_o = cor_q[CORDIC_ITERS-1].z;

endmodule

[hdl/stereo_point_reproject_azimuth.sv]
// ----------------------------------------------------------------------------
// stereo_point_reproject_azimuth: stereo pixel to 3D point and azimuth
// Reprojects a pixel and its disparity to X, Y, Z and gives the azimuth of
// the point against the microphone array, all in fixed point.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while the output buffer has a free slot; the
// 32-stage divider and 23-stage CORDIC pipeline each take a new word in every such cycle.
// A two-word output buffer lets the pipeline keep taking words while one
// result waits; input ready drops only when both buffer slots are full.
// Reset (rst_ni low, asynchronous) clears all valid bits, empties the buffer and
// returns the configuration registers to zero with array_depth at 370.
module stereo_point_reproject_azimuth (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [spra_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [spra_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [spra_pkg::COORD_BITS-1:0]      pixel_x_i,
  input  logic [spra_pkg::COORD_BITS-1:0]      pixel_y_i,
  input  logic signed [spra_pkg::DISP_W-1:0]   disparity_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [spra_pkg::PNT_W-1:0]    point_x_o,
  output logic signed [spra_pkg::PNT_W-1:0]    point_y_o,
  output logic signed [spra_pkg::PNT_W-1:0]    point_z_o,
  output logic signed [spra_pkg::ANGO_W-1:0]   angle_deg_o,
  output logic [1:0]                           status_o
);
  import spra_pkg::*;

  localparam int LANES = 3;

  // Stage payloads.
  typedef struct packed {
    logic signed [PROD_W-1:0] prod;
    logic signed [NUM_W-1:0]  nx;
    logic signed [NUM_W-1:0]  ny;
    logic signed [NUM_W-1:0]  nz;
  } p1_t;

  typedef struct packed {
    logic signed [DEN_W-1:0] den;
    logic signed [NUM_W-1:0] nx;
    logic signed [NUM_W-1:0] ny;
    logic signed [NUM_W-1:0] nz;
  } p2_t;

  typedef struct packed {
    logic                    den_zero;
    logic                    den_neg;
    logic [DMAG_W-1:0]       dmag;
    logic [LANES-1:0]        nneg;
    logic [LANES-1:0][MAGN_W-1:0] nmag;
  } p3_t;

  typedef struct packed {
    logic                    den_zero;
    logic [LANES-1:0]        qneg;
  } div_side_t;

  typedef struct packed {
    logic signed [PNT_W-1:0] xs;
    logic signed [PNT_W-1:0] ys;
    logic signed [PNT_W-1:0] zs;
    logic                    den_zero;
  } p5_t;

  typedef struct packed {
    logic signed [PNT_W-1:0] xs;
    logic signed [PNT_W-1:0] ys;
    logic signed [PNT_W-1:0] zs;
    logic signed [DZ_W-1:0]  dz;
    logic                    den_zero;
  } p6_t;

  typedef struct packed {
    logic signed [PNT_W-1:0] xs;
    logic signed [PNT_W-1:0] ys;
    logic signed [PNT_W-1:0] zs;
    logic                    den_zero;
    logic                    dz_zero;
    logic                    x_zero;
    logic                    neg;
  } cor_side_t;

  typedef struct packed {
    logic signed [PNT_W-1:0]  xs;
    logic signed [PNT_W-1:0]  ys;
    logic signed [PNT_W-1:0]  zs;
    logic signed [ANGO_W-1:0] ang;
    status_e                  status;
  } out_t;

  // Saturate a quotient magnitude with its sign to 32 bits.
  function automatic logic signed [PNT_W-1:0] sat_quo(input logic [QUO_W-1:0] q,
                                                      input logic ovf,
                                                      input logic neg);
    logic signed [PNT_W-1:0] r;
    if (neg) begin
      if (ovf || (q > {1'b1, {(QUO_W-1){1'b0}}})) begin
        r = {1'b1, {(PNT_W-1){1'b0}}};
      end else begin
        r = PNT_W'(-q);
      end
    end else begin
      if (ovf || q[QUO_W-1]) begin
        r = {1'b0, {(PNT_W-1){1'b1}}};
      end else begin
        r = PNT_W'(q);
      end
    end
    return r;
  endfunction

  // Configuration registers.
  logic signed [CFG_W-1:0] offset_x_q, offset_y_q, focal_length_q;
  logic signed [CFG_W-1:0] inv_baseline_q, center_shift_q;
  logic [DEPTH_W-1:0]      array_depth_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_x_q     <= '0;
      offset_y_q     <= '0;
      focal_length_q <= '0;
      inv_baseline_q <= '0;
      center_shift_q <= '0;
      array_depth_q  <= DEPTH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OFFSET_X:     offset_x_q     <= cfg_data_i;
        CFG_OFFSET_Y:     offset_y_q     <= cfg_data_i;
        CFG_FOCAL_LENGTH: focal_length_q <= cfg_data_i;
        CFG_INV_BASELINE: inv_baseline_q <= cfg_data_i;
        CFG_CENTER_SHIFT: center_shift_q <= cfg_data_i;
        CFG_ARRAY_DEPTH:  array_depth_q  <= cfg_data_i[DEPTH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The whole pipeline advances together whenever the output buffer has a
  // free slot, so a stall neither drops nor duplicates a word.
  logic [1:0] buf_cnt_q;
  logic       en;

  assign en         = (buf_cnt_q != 2'd2);
  assign in_ready_o = en;

  // Stage 1: disparity product and the pixel numerators.
  p1_t  p1_d, p1_q;
  logic p1_v_q;

  always_comb begin
    p1_d.prod = PROD_W'(disparity_i) * PROD_W'(inv_baseline_q);
    p1_d.nx   = signed'(NUM_W'({pixel_x_i, 16'b0})) + NUM_W'(offset_x_q);
    p1_d.ny   = signed'(NUM_W'({pixel_y_i, 16'b0})) + NUM_W'(offset_y_q);
    p1_d.nz   = NUM_W'(focal_length_q);
  end

  // Stage 2: the denominator carries 28 fraction bits, so the constant term
  // is scaled up by sixteen to line up with the disparity product.
  p2_t  p2_d, p2_q;
  logic p2_v_q;

  always_comb begin
    p2_d.den = DEN_W'(p1_q.prod) + (DEN_W'(center_shift_q) <<< 4);
    p2_d.nx  = p1_q.nx;
    p2_d.ny  = p1_q.ny;
    p2_d.nz  = p1_q.nz;
  end

  // Stage 3: split every operand into sign and magnitude.
  p3_t  p3_d, p3_q;
  logic p3_v_q;
  logic signed [NUM_W-1:0] num_lane [LANES];

  assign num_lane[0] = p2_q.nx;
  assign num_lane[1] = p2_q.ny;
  assign num_lane[2] = p2_q.nz;

  always_comb begin
    p3_d.den_zero = (p2_q.den == '0);
    p3_d.den_neg  = p2_q.den[DEN_W-1];
    p3_d.dmag     = p2_q.den[DEN_W-1] ? DMAG_W'(-p2_q.den) : DMAG_W'(p2_q.den);
    for (int l = 0; l < LANES; l++) begin
      p3_d.nneg[l] = num_lane[l][NUM_W-1];
      p3_d.nmag[l] = num_lane[l][NUM_W-1] ? MAGN_W'(-num_lane[l])
                                          : MAGN_W'(num_lane[l]);
    end
  end

  // Stage 4: rounding to nearest is folded into the division as
  // floor((2n + d) / 2d), with n already scaled by 2^20.
  logic [N_W-1:0]  p4_num_q [LANES];
  logic [D2_W-1:0] p4_den_q;
  div_side_t       p4_side_q;
  logic            p4_v_q;

  // Sideband and valid bits ride alongside the divider stages.
  div_side_t        div_side_q [QUO_W];
  logic [QUO_W-1:0] div_v_q;
  logic [QUO_W-1:0] quo [LANES];
  logic [LANES-1:0] ovf;

  for (genvar l = 0; l < LANES; l++) begin : g_div
    spra_divider u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (p4_num_q[l]),
      .den_i (p4_den_q),
      .quo_o (quo[l]),
      .ovf_o (ovf[l])
    );
  end

  // Stage 5: saturate the three quotients.
  p5_t  p5_d, p5_q;
  logic p5_v_q;

  always_comb begin
    p5_d.xs       = sat_quo(quo[0], ovf[0], div_side_q[QUO_W-1].qneg[0]);
    p5_d.ys       = sat_quo(quo[1], ovf[1], div_side_q[QUO_W-1].qneg[1]);
    p5_d.zs       = sat_quo(quo[2], ovf[2], div_side_q[QUO_W-1].qneg[2]);
    p5_d.den_zero = div_side_q[QUO_W-1].den_zero;
  end

  // Stage 6: depth from the array, with array_depth in whole units.
  p6_t  p6_d, p6_q;
  logic p6_v_q;

  always_comb begin
    p6_d.xs       = p5_q.xs;
    p6_d.ys       = p5_q.ys;
    p6_d.zs       = p5_q.zs;
    p6_d.den_zero = p5_q.den_zero;
    p6_d.dz       = DZ_W'(p5_q.zs) - signed'(DZ_W'({array_depth_q, 8'b0}));
  end

  // Stage 7: magnitudes for the CORDIC, quadrant sign and special cases.
  cor_side_t         p7_d, p7_q;
  logic [NORM_W-1:0] p7_a_d, p7_b_d, p7_a_q, p7_b_q;
  logic              p7_v_q;

  always_comb begin
    p7_d.xs       = p6_q.xs;
    p7_d.ys       = p6_q.ys;
    p7_d.zs       = p6_q.zs;
    p7_d.den_zero = p6_q.den_zero;
    p7_d.dz_zero  = (p6_q.dz == '0);
    p7_d.x_zero   = (p6_q.xs == '0);
    p7_d.neg      = p6_q.xs[PNT_W-1] ^ p6_q.dz[DZ_W-1];
    p7_a_d        = p6_q.dz[DZ_W-1] ? NORM_W'(-p6_q.dz) : NORM_W'(p6_q.dz);
    p7_b_d        = p6_q.xs[PNT_W-1] ? NORM_W'(-DZ_W'(p6_q.xs)) : NORM_W'(p6_q.xs);
  end

  cor_side_t             cor_side_q [CORDIC_LAT];
  logic [CORDIC_LAT-1:0] cor_v_q;
  logic signed [ANG_W-1:0] cor_z;

  spra_cordic u_cordic (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (p7_a_q),
    .b_i   (p7_b_q),
    .z_o   (cor_z)
  );

  // Valid bits of the arithmetic stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q  <= 1'b0;
      p2_v_q  <= 1'b0;
      p3_v_q  <= 1'b0;
      p4_v_q  <= 1'b0;
      div_v_q <= '0;
      p5_v_q  <= 1'b0;
      p6_v_q  <= 1'b0;
      p7_v_q  <= 1'b0;
      cor_v_q <= '0;
    end else if (en) begin
      p1_v_q  <= in_valid_i;
      p2_v_q  <= p1_v_q;
      p3_v_q  <= p2_v_q;
      p4_v_q  <= p3_v_q;
      div_v_q <= {div_v_q[QUO_W-2:0], p4_v_q};
      p5_v_q  <= div_v_q[QUO_W-1];
      p6_v_q  <= p5_v_q;
      p7_v_q  <= p6_v_q;
      cor_v_q <= {cor_v_q[CORDIC_LAT-2:0], p7_v_q};
    end
  end

  // Payload of the arithmetic stages.
  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q <= p1_d;
      p2_q <= p2_d;
      p3_q <= p3_d;
      for (int l = 0; l < LANES; l++) begin
        p4_num_q[l] <= N_W'({p3_q.nmag[l], 21'b0}) + N_W'(p3_q.dmag);
        p4_side_q.qneg[l] <= p3_q.nneg[l] ^ p3_q.den_neg;
      end
      p4_den_q           <= {p3_q.dmag, 1'b0};
      p4_side_q.den_zero <= p3_q.den_zero;
      p5_q   <= p5_d;
      p6_q   <= p6_d;
      p7_q   <= p7_d;
      p7_a_q <= p7_a_d;
      p7_b_q <= p7_b_d;
    end
  end

  for (genvar j = 0; j < QUO_W; j++) begin : g_div_side
    always_ff @(posedge clk_i) begin
      if (en) begin
        div_side_q[j] <= (j == 0) ? p4_side_q : div_side_q[(j == 0) ? 0 : j - 1];
      end
    end
  end

  for (genvar j = 0; j < CORDIC_LAT; j++) begin : g_cor_side
    always_ff @(posedge clk_i) begin
      if (en) begin
        cor_side_q[j] <= (j == 0) ? p7_q : cor_side_q[(j == 0) ? 0 : j - 1];
      end
    end
  end

  // Final step: clamp the angle to a quarter turn, round to 8 fraction bits,
  // apply the quadrant sign and pick the status.
  out_t                    res;
  cor_side_t               fin;
  logic signed [ANG_W-1:0] z_clamp;
  logic signed [ANG_W-1:0] z_round;
  logic [ANGO_W-1:0]       ang_mag;

  assign fin = cor_side_q[CORDIC_LAT-1];

  always_comb begin
    if (cor_z[ANG_W-1]) begin
      z_clamp = '0;
    end else if (cor_z > ANG_MAX) begin
      z_clamp = ANG_MAX;
    end else begin
      z_clamp = cor_z;
    end
    z_round = z_clamp + ANG_HALF_LSB;
    ang_mag = ANGO_W'(z_round >>> ANG_DROP);

    res.xs     = fin.xs;
    res.ys     = fin.ys;
    res.zs     = fin.zs;
    res.ang    = fin.neg ? signed'(-ang_mag) : signed'(ang_mag);
    res.status = STATUS_OK;
    if (fin.den_zero) begin
      res.xs     = '0;
      res.ys     = '0;
      res.zs     = '0;
      res.ang    = '0;
      res.status = STATUS_DEN_ZERO;
    end else if (fin.dz_zero) begin
      res.ang    = '0;
      res.status = STATUS_DEPTH_EQ;
    end else if (fin.x_zero) begin
      res.ang    = '0;
    end
  end

  // Two-word output buffer: slot 0 is presented, slot 1 absorbs the word
  // that was already in flight when the consumer stalled.
  out_t buf_q [2];
  logic push, pop;

  assign push = en && cor_v_q[CORDIC_LAT-1];
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_cnt_q <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   buf_cnt_q <= buf_cnt_q + 2'd1;
        2'b01:   buf_cnt_q <= buf_cnt_q - 2'd1;
        default: buf_cnt_q <= buf_cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case ({push, pop})
      2'b11: begin
        buf_q[0] <= res;
      end
      2'b10: begin
        if (buf_cnt_q == 2'd0) begin
          buf_q[0] <= res;
        end else begin
          buf_q[1] <= res;
        end
      end
      2'b01: begin
        buf_q[0] <= buf_q[1];
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = (buf_cnt_q != 2'd0);
  assign point_x_o   = buf_q[0].xs;
  assign point_y_o   = buf_q[0].ys;
  assign point_z_o   = buf_q[0].zs;
  assign angle_deg_o = buf_q[0].ang;
  assign status_o    = buf_q[0].status;

`ifndef NO_ASSERTIONS
  // A zero denominator must clear every numeric field of the word.
  a_den_zero_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_DEN_ZERO) |->
      (point_x_o == '0) && (point_y_o == '0) && (point_z_o == '0) &&
      (angle_deg_o == '0))
    else $error("zero denominator word carries nonzero fields");

  // No angle is given when the point sits at the array depth.
  a_depth_eq_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_DEPTH_EQ) |-> (angle_deg_o == '0))
    else $error("angle nonzero with Z at array depth");

  // The clamped and rounded angle never exceeds a quarter turn.
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (angle_deg_o <= 16'sd23040) && (angle_deg_o >= -16'sd23040))
    else $error("angle outside of plus or minus 90 degrees");

  // Input is held off only while a finished word waits.
  a_stall_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && (buf_cnt_q == 2'd2))
    else $error("input stalled without a waiting word");
`endif

endmodule
